/* src/esre_pkg.sv */
// Shared types, constants and a helper function for the ELLPACK row engine.
`timescale 1ns / 1ps

package esre_pkg;

  // Field widths fixed by the interface.
  localparam int INDEX_W   = 10;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int ROW_W     = 10;
  localparam int ROWLEN_W  = 7;
  localparam int NUMROWS_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  // Largest number of rows in one product.
  localparam int ROW_LIMIT = 1024;

  // Defaults for the top level parameters.
  localparam int DEF_VECTOR_DEPTH   = 1024;
  localparam int DEF_MAX_ROW_LENGTH = 64;
  localparam int DEF_FRACTION_BITS  = 16;

  // Item opcodes.
  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_ENTRY = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH      = 2'd0,
    CFG_NUM_ROWS        = 2'd1,
    CFG_ACCUMULATE_MODE = 2'd2
  } cfg_idx_t;

  // A finished row sum handed to the rounding stages.
  typedef struct packed {
    logic signed [ACC_W-1:0]  sum;
    logic signed [DATA_W-1:0] prior;
    logic [ROW_W-1:0]         row;
  } fin_req_t;

  // Signed 64-bit addition that clips at the signed limits.
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    logic signed [ACC_W-1:0] r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/esre_finish.sv */
// Row finishing stages: prior result add, rounding, Q16.16 clipping and output register.
`timescale 1ns / 1ps

module esre_finish #(
  parameter int FRACTION_BITS = esre_pkg::DEF_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accumulate_mode,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  esre_pkg::fin_req_t                  req,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [esre_pkg::ROW_W-1:0]          out_row_index,
  output logic signed [esre_pkg::DATA_W-1:0]  out_row_result,
  output logic                                out_saturated
);

  localparam int ACC_W  = esre_pkg::ACC_W;
  localparam int DATA_W = esre_pkg::DATA_W;
  localparam logic signed [ACC_W-1:0] ROUND_C = (64'sd1 <<< FRACTION_BITS) >>> 1;

  // Stage A holds the raw sum, stage B the sum with the prior result added in accumulate mode.
  logic                      a_v_r;
  esre_pkg::fin_req_t        a_r;
  logic                      b_v_r;
  logic signed [ACC_W-1:0]   b_total_r;
  logic [esre_pkg::ROW_W-1:0] b_row_r;
  logic                      out_valid_r;
  logic [esre_pkg::ROW_W-1:0] out_row_r;
  logic signed [DATA_W-1:0]  out_result_r;
  logic                      out_sat_r;

  logic out_free, b_free, a_free;
  logic signed [ACC_W-1:0] prior_sh, b_total_nxt;
  logic signed [ACC_W-1:0] rnd_sum, rnd_shift;
  logic signed [DATA_W-1:0] result_nxt;
  logic sat_nxt;

  // Each stage moves when the one after it is empty or moving.
  assign out_free  = !out_valid_r || !out_stall;
  assign b_free    = !b_v_r || out_free;
  assign a_free    = !a_v_r || b_free;
  assign req_ready = a_free;

  // Prior result aligned to the accumulator's fraction.
  always_comb begin
    prior_sh = ACC_W'(a_r.prior) <<< FRACTION_BITS;
    b_total_nxt = accumulate_mode ? esre_pkg::sat_add(a_r.sum, prior_sh) : a_r.sum;
  end

  // Round to nearest, ties upward, then clip to the 32-bit range.
  always_comb begin
    rnd_sum   = esre_pkg::sat_add(b_total_r, ROUND_C);
    rnd_shift = rnd_sum >>> FRACTION_BITS;
    if ((rnd_shift[ACC_W-1:DATA_W-1] == '0) || (rnd_shift[ACC_W-1:DATA_W-1] == '1)) begin
      result_nxt = rnd_shift[DATA_W-1:0];
      sat_nxt    = 1'b0;
    end else begin
      result_nxt = rnd_shift[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} :
                                        {1'b0, {(DATA_W-1){1'b1}}};
      sat_nxt    = 1'b1;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_free) a_v_r <= req_valid;
      if (b_free) b_v_r <= a_v_r;
      if (out_free) out_valid_r <= b_v_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (a_free && req_valid) a_r <= req;
    if (b_free && a_v_r) begin
      b_total_r <= b_total_nxt;
      b_row_r   <= a_r.row;
    end
    if (out_free && b_v_r) begin
      out_row_r    <= b_row_r;
      out_result_r <= result_nxt;
      out_sat_r    <= sat_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_index  = out_row_r;
  assign out_row_result = out_result_r;
  assign out_saturated  = out_sat_r;

endmodule

/* src/ellpack_spmv_row_engine.sv */
// Top level of the ELLPACK sparse matrix-vector row engine.
`timescale 1ns / 1ps

// Usage:
// Items enter on the in_ channel (in_valid, in_stall). A load item (opcode 0)
// writes value into the vector store at index. A matrix entry (opcode 1)
// multiplies value by the stored element at column index and adds the exact
// product into a 64-bit accumulator. After row_length entries the block emits
// one item on the out_ channel: the row index, the rounded and clipped Q16.16
// row value and a flag that tells whether clipping happened.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// row_length, num_rows and accumulate_mode; write it only while idle.
// Throughput is one item per cycle, loads and entries alike, while in_stall is
// low. A result passes through memory read, multiply, accumulate, prior add,
// rounding and clipping on its way to the out_ channel. Every stage moves when
// the stage after it is free, so input keeps flowing while a result waits;
// in_stall rises only once all stages are occupied behind a stalled result.
// Reset clears the accumulator, the counters, the stage valid bits and the
// configuration registers; vector store contents are undefined until loaded.
module ellpack_spmv_row_engine #(
  parameter int VECTOR_DEPTH   = esre_pkg::DEF_VECTOR_DEPTH,
  parameter int MAX_ROW_LENGTH = esre_pkg::DEF_MAX_ROW_LENGTH,
  parameter int FRACTION_BITS  = esre_pkg::DEF_FRACTION_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [0:0]                            in_opcode,
  input  logic [esre_pkg::INDEX_W-1:0]          in_index,
  input  logic signed [esre_pkg::DATA_W-1:0]    in_value,
  input  logic signed [esre_pkg::DATA_W-1:0]    in_prior_result,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [esre_pkg::ROW_W-1:0]            out_row_index,
  output logic signed [esre_pkg::DATA_W-1:0]    out_row_result,
  output logic                                  out_saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [esre_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [esre_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int AW     = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int CW     = $clog2(MAX_ROW_LENGTH + 1);
  localparam int DATA_W = esre_pkg::DATA_W;
  localparam int ACC_W  = esre_pkg::ACC_W;
  localparam int ROW_W  = esre_pkg::ROW_W;
  localparam int NR_W   = esre_pkg::NUMROWS_W;

  // Configuration registers.
  logic [esre_pkg::ROWLEN_W-1:0] row_length_r;
  logic [NR_W-1:0]               num_rows_r;
  logic                          accumulate_mode_r;

  // Vector store.
  logic signed [DATA_W-1:0] vec_mem [VECTOR_DEPTH];

  // Stage 1: element read from the store.
  logic                     s1_v_r;
  logic signed [DATA_W-1:0] s1_val_r;
  logic signed [DATA_W-1:0] s1_prior_r;
  logic                     s1_rng_r;
  logic signed [DATA_W-1:0] s1_elem_r;

  // Stage 2: product.
  logic                     s2_v_r;
  logic signed [ACC_W-1:0]  s2_prod_r;
  logic signed [DATA_W-1:0] s2_prior_r;

  // Row state.
  logic signed [ACC_W-1:0]  row_sum_r;
  logic [CW-1:0]            entry_count_r;
  logic [ROW_W-1:0]         row_count_r;

  logic in_accept, entry_take, load_take, in_rng;
  logic [esre_pkg::INDEX_W+AW-1:0] idx_ext;
  logic [AW-1:0] addr;
  logic free1, free2, adv2;
  logic signed [DATA_W-1:0] elem_sel;
  logic [CW-1:0] len_eff, cnt_inc;
  logic last2;
  logic [NR_W-1:0] rows_eff, row_inc;
  logic signed [ACC_W-1:0] sum_nxt;
  logic fin_ready, fin_valid;
  esre_pkg::fin_req_t fin_req;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r      <= esre_pkg::ROWLEN_W'(1);
      num_rows_r        <= NR_W'(1);
      accumulate_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        esre_pkg::CFG_ROW_LENGTH:      row_length_r <= cfg_data[esre_pkg::ROWLEN_W-1:0];
        esre_pkg::CFG_NUM_ROWS:        num_rows_r <= cfg_data[NR_W-1:0];
        esre_pkg::CFG_ACCUMULATE_MODE: accumulate_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input handshake and address decode.
  assign in_stall   = !free1;
  assign in_accept  = in_valid && !in_stall;
  assign entry_take = in_accept && (in_opcode == esre_pkg::OP_ENTRY);
  assign load_take  = in_accept && (in_opcode == esre_pkg::OP_LOAD);
  assign idx_ext    = (esre_pkg::INDEX_W + AW)'(in_index);
  assign addr       = idx_ext[AW-1:0];
  assign in_rng     = (32'(in_index) < 32'(VECTOR_DEPTH));

  // Store write for loads, registered read for matrix entries.
  always_ff @(posedge clk) begin
    if (load_take && in_rng) vec_mem[addr] <= in_value;
    if (entry_take && in_rng) s1_elem_r <= vec_mem[addr];
  end

  // Pipeline flow control; only last entries need the finishing stages.
  assign fin_valid = s2_v_r && last2;
  assign adv2      = s2_v_r && (!last2 || fin_ready);
  assign free2     = !s2_v_r || adv2;
  assign free1     = !s1_v_r || free2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (free1) s1_v_r <= entry_take;
      if (free2) s2_v_r <= s1_v_r;
    end
  end

  // Stage payloads; a column beyond the store reads as zero.
  assign elem_sel = s1_rng_r ? s1_elem_r : '0;

  always_ff @(posedge clk) begin
    if (entry_take) begin
      s1_val_r   <= in_value;
      s1_prior_r <= in_prior_result;
      s1_rng_r   <= in_rng;
    end
    if (free2 && s1_v_r) begin
      s2_prod_r  <= s1_val_r * elem_sel;
      s2_prior_r <= s1_prior_r;
    end
  end

  // Effective row length and end-of-row detection.
  always_comb begin
    if (row_length_r == '0) begin
      len_eff = CW'(1);
    end else if (32'(row_length_r) > 32'(MAX_ROW_LENGTH)) begin
      len_eff = CW'(MAX_ROW_LENGTH);
    end else begin
      len_eff = CW'(row_length_r);
    end
    cnt_inc = entry_count_r + CW'(1);
    last2   = (cnt_inc >= len_eff);
  end

  // Effective row count and next row index.
  always_comb begin
    if (num_rows_r == '0) begin
      rows_eff = NR_W'(1);
    end else if (num_rows_r > NR_W'(esre_pkg::ROW_LIMIT)) begin
      rows_eff = NR_W'(esre_pkg::ROW_LIMIT);
    end else begin
      rows_eff = num_rows_r;
    end
    row_inc = NR_W'(row_count_r) + NR_W'(1);
  end

  // Accumulator with saturation.
  assign sum_nxt = esre_pkg::sat_add(row_sum_r, s2_prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_sum_r     <= '0;
      entry_count_r <= '0;
      row_count_r   <= '0;
    end else if (adv2) begin
      if (last2) begin
        row_sum_r     <= '0;
        entry_count_r <= '0;
        row_count_r   <= (row_inc >= rows_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        row_sum_r     <= sum_nxt;
        entry_count_r <= cnt_inc;
      end
    end
  end

  assign fin_req.sum   = sum_nxt;
  assign fin_req.prior = s2_prior_r;
  assign fin_req.row   = row_count_r;

  esre_finish #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_finish (
    .clk             (clk),
    .rst_n           (rst_n),
    .accumulate_mode (accumulate_mode_r),
    .req_valid       (fin_valid),
    .req_ready       (fin_ready),
    .req             (fin_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_index   (out_row_index),
    .out_row_result  (out_row_result),
    .out_saturated   (out_saturated)
  );

  // The entry counter never reaches the row length limit.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r < CW'(MAX_ROW_LENGTH))
    else $error("entry counter out of range");

  // A last entry that waits for the finishing stages leaves the row state alone.
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && last2 && !fin_ready) |=> ($stable(row_sum_r) && $stable(row_count_r) && s2_v_r))
    else $error("row state changed while last entry was held");

  // An empty first stage never stalls the input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> !in_stall)
    else $error("input stalled with empty first stage");

  // A load never enters the arithmetic stages.
  a_load_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    load_take |=> !s1_v_r)
    else $error("load item entered the pipeline");

endmodule

/* dv/tb_ellpack_spmv_row_engine.sv */
// Self-checking testbench for the ELLPACK sparse matrix-vector row engine.
`timescale 1ns / 1ps

module tb_ellpack_spmv_row_engine;

  localparam int FRAC       = esre_pkg::DEF_FRACTION_BITS;
  localparam int INDEX_W    = esre_pkg::INDEX_W;
  localparam int DATA_W     = esre_pkg::DATA_W;
  localparam int ROW_W      = esre_pkg::ROW_W;
  localparam int CFG_IDX_W  = esre_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = esre_pkg::CFG_DATA_W;
  localparam int ROWLEN_W   = esre_pkg::ROWLEN_W;
  localparam int NUMROWS_W  = esre_pkg::NUMROWS_W;
  localparam int VEC_DEPTH  = esre_pkg::DEF_VECTOR_DEPTH;
  localparam int MAX_LEN    = esre_pkg::DEF_MAX_ROW_LENGTH;
  localparam int ROW_LIMIT  = esre_pkg::ROW_LIMIT;
  localparam int TAIL_WAIT  = 16;
  localparam int HOLD_LEN   = 300;
  localparam int QUIET_MAX  = 2000;

  // One item on the input channel.
  typedef struct packed {
    esre_pkg::op_t            op;
    logic [INDEX_W-1:0]       idx;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] prior;
  } feed_item_t;

  // One row result on the output channel.
  typedef struct packed {
    logic [ROW_W-1:0]         row;
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } row_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [0:0]               in_opcode;
  logic [INDEX_W-1:0]       in_index;
  logic signed [DATA_W-1:0] in_value;
  logic signed [DATA_W-1:0] in_prior_result;
  logic                     out_valid;
  logic                     out_stall;
  logic [ROW_W-1:0]         out_row_index;
  logic signed [DATA_W-1:0] out_row_result;
  logic                     out_saturated;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  ellpack_spmv_row_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_index        (in_index),
    .in_value        (in_value),
    .in_prior_result (in_prior_result),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_index   (out_row_index),
    .out_row_result  (out_row_result),
    .out_saturated   (out_saturated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Stimulus and scoreboard state.
  feed_item_t  items_due[$];
  row_result_t row_results_due[$];
  int          items_pushed;
  int          items_taken;
  int          loads_taken;
  int          entries_taken;
  int          rows_checked;
  int          cfg_writes;
  int          settings_used;
  int          errors;
  int          quiet_cycles;
  logic        in_taken;
  bit          idle_on;
  int          tx_gap;
  int          rx_gap;
  int          hold_req;
  int          hold_ack;
  int          hold_left;

  // Generator's view of which vector elements have been loaded.
  bit gen_loaded [0:VEC_DEPTH-1];
  int gen_cols[$];

  // Shadow copy of the engine state.
  logic signed [DATA_W-1:0] vec_copy [0:VEC_DEPTH-1];
  longint                   mac_sum;
  int                       mac_entries;
  int                       mac_row;
  logic [ROWLEN_W-1:0]      shadow_len;
  logic [NUMROWS_W-1:0]     shadow_rows;
  logic                     shadow_acc;

  // 64-bit addition that clips at the signed limits.
  function automatic longint add_clip64(longint a, longint b);
    longint r;
    r = a + b;
    if (!a[63] && !b[63] && r[63]) begin
      r = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (a[63] && b[63] && !r[63]) begin
      r = 64'sh8000_0000_0000_0000;
    end
    return r;
  endfunction

  // Applies one accepted item to the shadow state; returns 1 when a row completes.
  function automatic bit mac_row_item(feed_item_t it, output row_result_t res);
    longint prod;
    longint total;
    longint rnd;
    int     len;
    int     rows;
    int     nxt;
    res = '0;
    if (it.op == esre_pkg::OP_LOAD) begin
      vec_copy[it.idx] = it.val;
      return 1'b0;
    end
    prod = longint'($signed(it.val)) * longint'($signed(vec_copy[it.idx]));
    mac_sum = add_clip64(mac_sum, prod);
    mac_entries++;
    len = (shadow_len == 0) ? 1 : int'(shadow_len);
    if (len > MAX_LEN) len = MAX_LEN;
    if (mac_entries < len) return 1'b0;

    // Row complete: optional prior add, round half up, clip to Q16.16.
    total = mac_sum;
    if (shadow_acc) total = add_clip64(total, longint'($signed(it.prior)) <<< FRAC);
    total = add_clip64(total, longint'(1) <<< (FRAC - 1));
    rnd = total >>> FRAC;
    res.sat = 1'b0;
    if (rnd > 64'sd2147483647) begin
      rnd = 64'sd2147483647;
      res.sat = 1'b1;
    end else if (rnd < -64'sd2147483648) begin
      rnd = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.row   = mac_row[ROW_W-1:0];
    res.value = rnd[DATA_W-1:0];

    rows = (shadow_rows == 0) ? 1 : int'(shadow_rows);
    if (rows > ROW_LIMIT) rows = ROW_LIMIT;
    nxt = mac_row + 1;
    if (nxt >= rows) nxt = 0;
    mac_row     = nxt;
    mac_sum     = 0;
    mac_entries = 0;
    return 1'b1;
  endfunction

  // Monitor: checks results, updates the shadow state and the watchdog count.
  always @(posedge clk) begin
    feed_item_t  cur;
    row_result_t want;
    row_result_t got;
    bit          fired;
    if (rst_n) begin
      fired = 1'b0;
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        fired = 1'b1;
        got.row   = out_row_index;
        got.value = out_row_result;
        got.sat   = out_saturated;
        if (row_results_due.size() == 0) begin
          $error("unexpected row result: row_index %0d row_result %0d", got.row, got.value);
          errors++;
        end else begin
          want = row_results_due.pop_front();
          if (got.row !== want.row) begin
            $error("row_index mismatch: expected %0d, actual %0d", want.row, got.row);
            errors++;
          end
          if (got.value !== want.value) begin
            $error("row_result mismatch: expected %0d, actual %0d", want.value, got.value);
            errors++;
          end
          if (got.sat !== want.sat) begin
            $error("saturated mismatch: expected %0d, actual %0d", want.sat, got.sat);
            errors++;
          end
          rows_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        fired = 1'b1;
        case (esre_pkg::cfg_idx_t'(cfg_index))
          esre_pkg::CFG_ROW_LENGTH: begin
            shadow_len = cfg_data[ROWLEN_W-1:0];
          end
          esre_pkg::CFG_NUM_ROWS: begin
            shadow_rows = cfg_data[NUMROWS_W-1:0];
          end
          esre_pkg::CFG_ACCUMULATE_MODE: begin
            shadow_acc = cfg_data[0];
          end
          default: begin
          end
        endcase
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        fired = 1'b1;
        cur.op    = esre_pkg::op_t'(in_opcode);
        cur.idx   = in_index;
        cur.val   = in_value;
        cur.prior = in_prior_result;
        if (cur.op == esre_pkg::OP_LOAD) loads_taken++;
        else entries_taken++;
        if (mac_row_item(cur, want)) row_results_due.push_back(want);
        items_taken++;
      end
      quiet_cycles = fired ? 0 : quiet_cycles + 1;
    end
  end

  // Driver: presents the next pending item once the current one is taken.
  always @(negedge clk) begin
    feed_item_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (items_due.size() != 0) begin
        nxt = items_due.pop_front();
        in_valid        <= 1'b1;
        in_opcode       <= nxt.op;
        in_index        <= nxt.idx;
        in_value        <= nxt.val;
        in_prior_result <= nxt.prior;
        if (idle_on && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus an occasional long hold-off.
  always @(negedge clk) begin
    logic hold;
    if (rst_n) begin
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        hold = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        hold = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 13);
        hold = 1'b1;
      end else begin
        hold = 1'b0;
      end
      out_stall <= hold;
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    wait (rst_n === 1'b1);
    while (quiet_cycles < QUIET_MAX) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Random 32-bit word leaning toward extremes and small magnitudes.
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    logic [19:0] low;
    case ($urandom_range(0, 7)) inside
      0: begin
        case ($urandom_range(0, 4))
          0: w = 32'h7FFF_FFFF;
          1: w = 32'h8000_0000;
          2: w = 32'h0000_0000;
          3: w = 32'hFFFF_FFFF;
          default: w = 32'h0000_0001;
        endcase
      end
      [1:3]: begin
        low = 20'($urandom());
        w = {{12{low[19]}}, low};
      end
      default: begin
        w = $urandom();
      end
    endcase
    return w;
  endfunction

  // A column whose vector element has already been loaded.
  function automatic logic [INDEX_W-1:0] rand_col();
    return INDEX_W'(gen_cols[$urandom_range(0, gen_cols.size() - 1)]);
  endfunction

  task automatic queue_item(esre_pkg::op_t op, logic [INDEX_W-1:0] idx, logic [31:0] val,
                            logic [31:0] prior);
    feed_item_t it;
    it.op    = op;
    it.idx   = idx;
    it.val   = val;
    it.prior = prior;
    items_due.push_back(it);
    items_pushed++;
    if (op == esre_pkg::OP_LOAD && !gen_loaded[idx]) begin
      gen_loaded[idx] = 1'b1;
      gen_cols.push_back(int'(idx));
    end
  endtask

  task automatic write_reg(esre_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every item is taken and every result has arrived, then lets
  // the pipeline empty.
  task automatic settle();
    while (items_due.size() != 0 || items_taken != items_pushed ||
           row_results_due.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);
  endtask

  task automatic apply_settings(int len, int rows, int acc);
    write_reg(esre_pkg::CFG_ROW_LENGTH, CFG_DATA_W'(len));
    write_reg(esre_pkg::CFG_NUM_ROWS, CFG_DATA_W'(rows));
    write_reg(esre_pkg::CFG_ACCUMULATE_MODE, CFG_DATA_W'(acc));
    settings_used++;
  endtask

  // Mostly whole rows with random content; some loads and cut-short rows mixed in.
  task automatic queue_rows(int n_items, int len);
    int left;
    int pick;
    int k;
    int j;
    left = n_items;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_item(esre_pkg::OP_LOAD, INDEX_W'($urandom_range(0, 1023)), rand_word(),
                   $urandom());
        left--;
      end else begin
        k = (pick < 14) ? $urandom_range(1, len) : len;
        for (j = 0; j < k; j++) begin
          if ($urandom_range(0, 19) == 0) begin
            queue_item(esre_pkg::OP_LOAD, INDEX_W'($urandom_range(0, 1023)), rand_word(),
                       $urandom());
            left--;
          end
          queue_item(esre_pkg::OP_ENTRY, rand_col(),
                     ($urandom_range(0, 5) == 0) ? 32'h0 : rand_word(), $urandom());
          left--;
        end
      end
    end
  endtask

  task automatic run_phase(int len, int rows, int acc, int n_items, bit long_hold);
    int eff;
    settle();
    apply_settings(len, rows, acc);
    eff = len % 128;
    if (eff < 1) eff = 1;
    if (eff > MAX_LEN) eff = MAX_LEN;
    if (long_hold) hold_req++;
    queue_rows(n_items, eff);
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_index = '0;
    in_value = '0;
    in_prior_result = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_taken = 1'b0;
    idle_on = 1'b1;
    tx_gap = 0;
    rx_gap = 0;
    hold_req = 0;
    hold_ack = 0;
    hold_left = 0;
    items_pushed = 0;
    items_taken = 0;
    loads_taken = 0;
    entries_taken = 0;
    rows_checked = 0;
    cfg_writes = 0;
    settings_used = 0;
    errors = 0;
    quiet_cycles = 0;
    mac_sum = 0;
    mac_entries = 0;
    mac_row = 0;
    shadow_len = 1;
    shadow_rows = 1;
    shadow_acc = 1'b0;
    for (i = 0; i < VEC_DEPTH; i++) begin
      gen_loaded[i] = 1'b0;
      vec_copy[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: one entry per row, rows always zero. Extremes, rounding ties.
    queue_item(esre_pkg::OP_LOAD, 10'd0, 32'h7FFF_FFFF, 32'h0);
    queue_item(esre_pkg::OP_LOAD, 10'd1023, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_item(esre_pkg::OP_LOAD, 10'd5, 32'h0001_0000, 32'h0);
    queue_item(esre_pkg::OP_LOAD, 10'd6, 32'h0000_8000, 32'h0);
    queue_item(esre_pkg::OP_ENTRY, 10'd5, 32'h0001_0000, 32'h7FFF_FFFF);
    queue_item(esre_pkg::OP_ENTRY, 10'd6, 32'h0000_0001, 32'h0);
    queue_item(esre_pkg::OP_ENTRY, 10'd6, 32'hFFFF_FFFF, 32'h0);
    queue_item(esre_pkg::OP_ENTRY, 10'd0, 32'h7FFF_FFFF, 32'h0);
    queue_item(esre_pkg::OP_ENTRY, 10'd1023, 32'h7FFF_FFFF, 32'h0);

    // Accumulator overflow both ways, then a padded row with a prior result.
    settle();
    apply_settings(4, 3, 1);
    for (i = 0; i < 4; i++) begin
      queue_item(esre_pkg::OP_ENTRY, 10'd1023, 32'h8000_0000, 32'h7FFF_FFFF);
    end
    for (i = 0; i < 4; i++) begin
      queue_item(esre_pkg::OP_ENTRY, 10'd0, 32'h8000_0000, 32'h8000_0000);
    end
    queue_item(esre_pkg::OP_ENTRY, 10'd5, 32'h0001_0000, 32'h1234_5678);
    for (i = 0; i < 3; i++) begin
      queue_item(esre_pkg::OP_ENTRY, 10'd6, 32'h0, (i == 2) ? 32'h8000_0000 : 32'h0);
    end

    // Row length lowered below the entries already taken in the current row.
    for (i = 0; i < 3; i++) queue_item(esre_pkg::OP_ENTRY, 10'd5, 32'h0002_0000, 32'h0);
    settle();
    write_reg(esre_pkg::CFG_ROW_LENGTH, 11'd2);
    queue_item(esre_pkg::OP_ENTRY, 10'd6, 32'h0004_0000, 32'h0001_0000);

    // Row count lowered below the current row: wraps after the next row.
    settle();
    write_reg(esre_pkg::CFG_NUM_ROWS, 11'd1);
    queue_item(esre_pkg::OP_ENTRY, 10'd5, 32'hFFFF_0000, 32'h0);
    queue_item(esre_pkg::OP_ENTRY, 10'd0, 32'h0000_0003, 32'hFFFF_FFFF);

    // Spread loads over the whole store before the random part.
    for (i = 0; i < 40; i++) begin
      queue_item(esre_pkg::OP_LOAD, INDEX_W'($urandom_range(0, 1023)), rand_word(),
                 $urandom());
    end

    // Random part over a range of settings, the extremes among them.
    run_phase(1, 1024, 0, 250, 1'b1);
    run_phase(64, 2, 1, 260, 1'b0);
    run_phase(0, 0, 1, 150, 1'b0);
    run_phase(127, 2047, 0, 130, 1'b0);
    for (i = 0; i < 4; i++) begin
      run_phase($urandom_range(1, 8), $urandom_range(1, 12), $urandom_range(0, 1), 170, 1'b0);
    end

    // Last stretch runs without any idling on either side.
    settle();
    idle_on = 1'b0;
    run_phase(3, 5, 1, 180, 1'b0);
    settle();

    $display("Run covered %0d items (%0d loads, %0d matrix entries) and %0d row results",
             items_taken, loads_taken, entries_taken, rows_checked);
    $display("across %0d register settings with %0d register writes.",
             settings_used, cfg_writes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/esre_pkg.sv
src/esre_finish.sv
src/ellpack_spmv_row_engine.sv
dv/tb_ellpack_spmv_row_engine.sv
